FILE: design/assert_macros.svh
// assertion macros shared by the rectangle painter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication on the same edge, disabled in reset
`define TRPP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// clocked implication on the next edge, disabled in reset
`define TRPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/trpp_pkg.sv
// types, register indexes and helpers for the thick rectangle pixel painter
package trpp_pkg;

	localparam int COORD_W = 16;
	localparam int PIX_W   = 15;
	localparam int DIFF_W  = 18;
	localparam int IDX_W   = 8;
	localparam int DATA_W  = 24;

	typedef enum logic [IDX_W-1:0] {
		REG_CORNER_A_X = 8'd0,
		REG_CORNER_A_Y = 8'd1,
		REG_CORNER_B_X = 8'd2,
		REG_CORNER_B_Y = 8'd3,
		REG_LINE_WIDTH = 8'd4,
		REG_BORDER_RGB = 8'd5,
		REG_FILL_RGB   = 8'd6,
		REG_FILL_ON    = 8'd7
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix_x;
		logic [PIX_W-1:0] pix_y;
		logic [7:0]       in_red;
		logic [7:0]       in_green;
		logic [7:0]       in_blue;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} pix_out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] y0;
		logic signed [COORD_W-1:0] y1;
		logic [7:0]                thick;
		logic [23:0]               border_rgb;
		logic [23:0]               fill_rgb;
		logic                      fill_on;
	} cfg_t;

	// distance magnitude truncated to its low 8 bits, with a flag for 256 and beyond
	typedef struct packed {
		logic       far;
		logic [7:0] mag;
	} dist_t;

	function automatic dist_t dist_mag(logic signed [DIFF_W-1:0] d);
		logic [DIFF_W-1:0] m;
		dist_t             r;
		m     = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
		r.far = |m[DIFF_W-1:8];
		r.mag = m[7:0];
		return r;
	endfunction

endpackage

FILE: design/trpp_cfg.sv
// configuration registers with corner order normalized
module trpp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [trpp_pkg::IDX_W-1:0]     wr_index,
	input  logic [trpp_pkg::DATA_W-1:0]    wr_data,
	output trpp_pkg::cfg_t                 cfg
);

	logic signed [trpp_pkg::COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic [7:0]                          thick_q;
	logic [23:0]                         border_q, fill_q;
	logic                                fill_on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q      <= '0;
			ay_q      <= '0;
			bx_q      <= '0;
			by_q      <= '0;
			thick_q   <= '0;
			border_q  <= '0;
			fill_q    <= '0;
			fill_on_q <= 1'b0;
		end else if (wr_en) begin
			unique case (trpp_pkg::reg_idx_t'(wr_index))
				trpp_pkg::REG_CORNER_A_X: ax_q <= wr_data[trpp_pkg::COORD_W-1:0];
				trpp_pkg::REG_CORNER_A_Y: ay_q <= wr_data[trpp_pkg::COORD_W-1:0];
				trpp_pkg::REG_CORNER_B_X: bx_q <= wr_data[trpp_pkg::COORD_W-1:0];
				trpp_pkg::REG_CORNER_B_Y: by_q <= wr_data[trpp_pkg::COORD_W-1:0];
				trpp_pkg::REG_LINE_WIDTH: thick_q <= wr_data[7:0];
				trpp_pkg::REG_BORDER_RGB: border_q <= wr_data[23:0];
				trpp_pkg::REG_FILL_RGB:   fill_q <= wr_data[23:0];
				trpp_pkg::REG_FILL_ON:    fill_on_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.x0         = (ax_q < bx_q) ? ax_q : bx_q;
		cfg.x1         = (ax_q < bx_q) ? bx_q : ax_q;
		cfg.y0         = (ay_q < by_q) ? ay_q : by_q;
		cfg.y1         = (ay_q < by_q) ? by_q : ay_q;
		cfg.thick      = thick_q;
		cfg.border_rgb = border_q;
		cfg.fill_rgb   = fill_q;
		cfg.fill_on    = fill_on_q;
	end

endmodule

FILE: design/thick_rect_pixel_painter.sv
// thick rectangle pixel painter: three-stage pixel pipeline ending in an output register
//
// Usage
//   in channel:  in_valid / in_ready / in_data, one pixel with its coordinate.
//   out channel: out_valid / out_ready / out_data, the new color of that pixel.
//   cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data, register writes;
//     cfg_ready is always high, indexes above the register list are ignored.
//   Write configuration only while no pixel is in flight.
// Pipeline and throughput
//   An accepted pixel passes the stage 1 and 2 registers and then the output register.
//   One pixel per cycle is sustained while out_ready stays high; the stages are
//   corner differences, squares and band tests, then disk compare and color select.
// Reset
//   arst_n low empties the pipeline and clears the configuration registers to zero.
// Stalls
//   When out_ready is low the result holds; earlier stages keep filling
//   until every stage is full, then in_ready falls. No pixel is lost.
`include "assert_macros.svh"

module thick_rect_pixel_painter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  trpp_pkg::pix_in_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output trpp_pkg::pix_out_t          out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [trpp_pkg::IDX_W-1:0]  cfg_index,
	input  logic [trpp_pkg::DATA_W-1:0] cfg_data
);

	localparam int DW = trpp_pkg::DIFF_W;

	trpp_pkg::cfg_t cfg;

	assign cfg_ready = 1'b1;

	trpp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// stage enables
	logic v_s1, v_s2, out_valid_q;
	logic en_s1, en_s2, en_out;

	assign en_out   = !out_valid_q || out_ready;
	assign en_s2    = !v_s2 || en_out;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1 <= in_valid;
			if (en_s2)  v_s2 <= v_s1;
			if (en_out) out_valid_q <= v_s2;
		end
	end

	// stage 1: differences to the corner lines
	logic signed [DW-1:0] px, py;
	logic signed [DW-1:0] dx0_s1, dx1_s1, dy0_s1, dy1_s1;
	logic [23:0]          rgb_s1;

	assign px = $signed({{(DW-trpp_pkg::PIX_W){1'b0}}, in_data.pix_x});
	assign py = $signed({{(DW-trpp_pkg::PIX_W){1'b0}}, in_data.pix_y});

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			dx0_s1 <= px - DW'(cfg.x0);
			dx1_s1 <= px - DW'(cfg.x1);
			dy0_s1 <= py - DW'(cfg.y0);
			dy1_s1 <= py - DW'(cfg.y1);
			rgb_s1 <= {in_data.in_red, in_data.in_green, in_data.in_blue};
		end
	end

	// stage 2: band and interior tests, squared distances
	logic [8:0]              half_up;
	logic signed [DW-1:0]    band_lo, band_hi;
	logic signed [DW:0]      two_t, two_t_neg;
	logic                    in_x, in_y, band, inner;
	trpp_pkg::dist_t         mx0, mx1, my0, my1;
	logic [15:0]             sqx0_s2, sqx1_s2, sqy0_s2, sqy1_s2, tsq_s2;
	logic                    fx0_s2, fx1_s2, fy0_s2, fy1_s2;
	logic                    band_s2, inner_s2;
	logic [23:0]             rgb_s2;

	always_comb begin
		half_up   = (9'(cfg.thick) + 9'd1) >> 1;
		band_lo   = DW'(0) - $signed(DW'(half_up));
		band_hi   = $signed(DW'(cfg.thick >> 1));
		two_t     = $signed((DW+1)'(cfg.thick));
		two_t_neg = (DW+1)'(0) - two_t;
		in_x      = !dx0_s1[DW-1] && (dx1_s1 <= 0);
		in_y      = !dy0_s1[DW-1] && (dy1_s1 <= 0);
		band      = (in_x && ((dy0_s1 >= band_lo && dy0_s1 <= band_hi) ||
			(dy1_s1 >= band_lo && dy1_s1 <= band_hi))) ||
			(in_y && ((dx0_s1 >= band_lo && dx0_s1 <= band_hi) ||
			(dx1_s1 >= band_lo && dx1_s1 <= band_hi)));
		inner     = cfg.fill_on && in_x && in_y &&
			($signed({dx0_s1, 1'b0}) >= two_t) && ($signed({dx1_s1, 1'b0}) <= two_t_neg) &&
			($signed({dy0_s1, 1'b0}) >= two_t) && ($signed({dy1_s1, 1'b0}) <= two_t_neg);
		mx0       = trpp_pkg::dist_mag(dx0_s1);
		mx1       = trpp_pkg::dist_mag(dx1_s1);
		my0       = trpp_pkg::dist_mag(dy0_s1);
		my1       = trpp_pkg::dist_mag(dy1_s1);
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			sqx0_s2  <= mx0.mag * mx0.mag;
			sqx1_s2  <= mx1.mag * mx1.mag;
			sqy0_s2  <= my0.mag * my0.mag;
			sqy1_s2  <= my1.mag * my1.mag;
			tsq_s2   <= cfg.thick * cfg.thick;
			fx0_s2   <= mx0.far;
			fx1_s2   <= mx1.far;
			fy0_s2   <= my0.far;
			fy1_s2   <= my1.far;
			band_s2  <= band;
			inner_s2 <= inner;
			rgb_s2   <= rgb_s1;
		end
	end

	// stage 3: corner disks and color select
	logic [18:0] d00, d10, d01, d11, tsq_w;
	logic        border;
	logic [23:0] rgb_out_q;

	always_comb begin
		tsq_w  = 19'(tsq_s2);
		d00    = (19'(sqx0_s2) + 19'(sqy0_s2)) << 2;
		d10    = (19'(sqx1_s2) + 19'(sqy0_s2)) << 2;
		d01    = (19'(sqx0_s2) + 19'(sqy1_s2)) << 2;
		d11    = (19'(sqx1_s2) + 19'(sqy1_s2)) << 2;
		border = band_s2 ||
			(!fx0_s2 && !fy0_s2 && d00 <= tsq_w) ||
			(!fx1_s2 && !fy0_s2 && d10 <= tsq_w) ||
			(!fx0_s2 && !fy1_s2 && d01 <= tsq_w) ||
			(!fx1_s2 && !fy1_s2 && d11 <= tsq_w);
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			if (border) begin
				rgb_out_q <= cfg.border_rgb;
			end else if (inner_s2) begin
				rgb_out_q <= cfg.fill_rgb;
			end else begin
				rgb_out_q <= rgb_s2;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign out_data.out_red   = rgb_out_q[23:16];
	assign out_data.out_green = rgb_out_q[15:8];
	assign out_data.out_blue  = rgb_out_q[7:0];

	`TRPP_ASSERT_SAME(a_ready_when_out_free, !out_valid_q, in_ready,
		"input stalled with an empty output register")
	`TRPP_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, v_s1,
		"accepted item missing from first stage")
	`TRPP_ASSERT_NEXT(a_s2_moves_out, v_s2 && en_out, out_valid_q,
		"second stage item lost on its way to the output")
	`TRPP_ASSERT_NEXT(a_stall_holds_s2, v_s2 && !en_out, v_s2 && $stable(rgb_s2),
		"second stage item changed during a stall")

endmodule
